@@ hw/rtl/circular_queue_buffer_top_macros.svh @@
// Assertion macros shared by the circular queue buffer RTL.
`ifndef CIRCULAR_QUEUE_BUFFER_TOP_MACROS_SVH
`define CIRCULAR_QUEUE_BUFFER_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CQB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circular queue buffer check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define CQB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circular queue buffer check failed");

`endif

@@ hw/rtl/cqb_pkg.sv @@
// Types and codes of the circular queue buffer.
package cqb_pkg;

  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [1:0] CMD_DISPLAY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam int unsigned ADDR_W = 3;
  localparam logic REG_QUEUE_LENGTH = 1'b0;
  localparam logic [6:0] QUEUE_LENGTH_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] push_value;
  } cqb_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_out;
    logic               last;
  } cqb_rsp_t;

endpackage

@@ hw/rtl/circular_queue_buffer_top.sv @@
// Circular FIFO of signed 32-bit values with a configurable length and a display walk.
//
// Each request carries a command: enqueue, dequeue or display. Enqueue and dequeue are
// taken one per cycle while req_stall is low; each gives one response, registered in s1
// and then in rsp. Display of a queue holding n entries gives n responses, oldest first,
// the last one marked; it holds off new requests until its last read is issued, since
// every response needs one read of the single entry memory port. A stalled response
// holds off new requests once both pipeline stages are full. Display of an empty queue,
// overflow and underflow give one status response each. Command 3 is taken and gives
// no response. Writing queue_length (byte address 0) empties the queue; a length of 0
// acts as 1 and a length above DEPTH acts as DEPTH. No clearing pass follows reset.
module circular_queue_buffer_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  cqb_pkg::cqb_req_t           req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output cqb_pkg::cqb_rsp_t           rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cqb_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned OW = $clog2(DEPTH + 1);

  logic [6:0]         queue_length;
  logic [IW-1:0]      head;
  logic [IW-1:0]      head_next;
  logic [IW-1:0]      tail;
  logic [IW-1:0]      tail_next;
  logic [OW-1:0]      occupancy;
  logic [OW-1:0]      occupancy_next;
  logic [OW-1:0]      walk_left;
  logic [OW-1:0]      walk_left_next;
  logic [IW-1:0]      walk_idx;
  logic [IW-1:0]      walk_idx_next;
  logic [OW-1:0]      len_eff;

  logic               s1_valid;
  logic [1:0]         s1_status;
  logic               s1_last;
  logic               s1_use_mem;
  logic               s1_move;
  logic               s1_load;

  logic               walking;
  logic               accept;
  logic               cfg_write;
  logic               issue;
  logic [1:0]         issue_status;
  logic               issue_last;
  logic               issue_use_mem;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;

  function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx,
                                            input logic [OW-1:0] len);
    logic [OW-1:0] nxt;
    nxt = OW'(idx) + OW'(1);
    return (nxt >= len) ? '0 : nxt[IW-1:0];
  endfunction

  always_comb begin
    if (queue_length == 7'd0) begin
      len_eff = OW'(1);
    end else if (queue_length > 7'(DEPTH)) begin
      len_eff = OW'(DEPTH);
    end else begin
      len_eff = queue_length[OW-1:0];
    end
  end

  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == cqb_pkg::REG_QUEUE_LENGTH);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == cqb_pkg::REG_QUEUE_LENGTH) ? {25'd0, queue_length} : 32'd0;

  assign walking   = (walk_left != '0);
  assign s1_move   = s1_valid && (!rsp_valid || !rsp_stall);
  assign s1_load   = !s1_valid || s1_move;
  assign req_stall = walking || !s1_load;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    occupancy_next = occupancy;
    walk_left_next = walk_left;
    walk_idx_next  = walk_idx;
    issue          = 1'b0;
    issue_status   = cqb_pkg::ST_OK;
    issue_last     = 1'b1;
    issue_use_mem  = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = head;
    wr_en          = 1'b0;
    if (walking) begin
      if (s1_load) begin
        issue          = 1'b1;
        issue_use_mem  = 1'b1;
        issue_last     = (walk_left == OW'(1));
        rd_en          = 1'b1;
        rd_addr        = walk_idx;
        walk_left_next = walk_left - OW'(1);
        walk_idx_next  = advance(walk_idx, len_eff);
      end
    end else if (accept) begin
      case (req.command)
        cqb_pkg::CMD_ENQUEUE: begin
          issue = 1'b1;
          if (occupancy >= len_eff) begin
            issue_status = cqb_pkg::ST_OVERFLOW;
          end else begin
            wr_en          = 1'b1;
            tail_next      = advance(tail, len_eff);
            occupancy_next = occupancy + OW'(1);
          end
        end
        cqb_pkg::CMD_DEQUEUE: begin
          issue = 1'b1;
          if (occupancy == '0) begin
            issue_status = cqb_pkg::ST_UNDERFLOW;
          end else begin
            issue_use_mem  = 1'b1;
            rd_en          = 1'b1;
            head_next      = advance(head, len_eff);
            occupancy_next = occupancy - OW'(1);
          end
        end
        cqb_pkg::CMD_DISPLAY: begin
          issue = 1'b1;
          if (occupancy == '0) begin
            issue_status = cqb_pkg::ST_EMPTY;
          end else begin
            issue_use_mem  = 1'b1;
            issue_last     = (occupancy == OW'(1));
            rd_en          = 1'b1;
            walk_left_next = occupancy - OW'(1);
            walk_idx_next  = advance(head, len_eff);
          end
        end
        default: begin
          issue = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= req.push_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_length <= cqb_pkg::QUEUE_LENGTH_RESET;
      head         <= '0;
      tail         <= '0;
      occupancy    <= '0;
      walk_left    <= '0;
      walk_idx     <= '0;
    end else if (cfg_write) begin
      queue_length <= pwdata[6:0];
      head         <= '0;
      tail         <= '0;
      occupancy    <= '0;
      walk_left    <= '0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      occupancy <= occupancy_next;
      walk_left <= walk_left_next;
      walk_idx  <= walk_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && issue) begin
      s1_status  <= issue_status;
      s1_last    <= issue_last;
      s1_use_mem <= issue_use_mem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp.status   <= s1_status;
      rsp.data_out <= s1_use_mem ? rd_data : 32'sd0;
      rsp.last     <= s1_last;
    end
  end

`include "circular_queue_buffer_top_macros.svh"

  `CQB_ASSERT_IMP(a_occ_bound, 1'b1, occupancy <= len_eff)
  `CQB_ASSERT_IMP(a_empty_aligned, occupancy == '0, head == tail)
  `CQB_ASSERT_IMP(a_walk_in_flight, walking, s1_valid)
  `CQB_ASSERT_NXT(a_rd_hold, s1_valid && !s1_move, s1_valid && (!s1_use_mem || $stable(rd_data)))

endmodule
